// ----- rtl/core/itrd_pkg.sv -----
package itrd_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int MAX_DIGITS_DEF = 31;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int OUT_TDATA_W = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [DIGIT_W-1:0] DIGIT_TOP    = 6'd35;
  localparam logic [DIGIT_W-1:0] DIGIT_DEC    = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA   = 7'd55;
  localparam logic [CHAR_W-1:0]  CHAR_LAST    = 7'd90;

  // Maps a digit value to its ASCII character: '0'-'9', then 'A'-'Z'.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_DEC) begin
      c = CHAR_ZERO + {1'b0, d};
    end else if (d <= DIGIT_TOP) begin
      c = CHAR_ALPHA + {1'b0, d};
    end else begin
      c = CHAR_LAST;
    end
    return c;
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] e;
    if (r < RADIX_MIN) begin
      e = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      e = RADIX_MAX;
    end else begin
      e = r;
    end
    return e;
  endfunction

endpackage

// ----- rtl/core/itrd_div.sv -----
module itrd_div #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [VALUE_BITS-1:0]        dividend,
  input  logic [itrd_pkg::RADIX_W-1:0] divisor,
  output logic                         busy,
  output logic                         done,
  output logic [VALUE_BITS-1:0]        quotient,
  output logic [itrd_pkg::RADIX_W-1:0] remainder
);
  import itrd_pkg::*;

  localparam int STEP_W = $clog2(VALUE_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [RADIX_W-1:0]    d_r, d_nxt;
  logic [RADIX_W:0]      shifted;
  logic [RADIX_W:0]      diff;
  logic                  ge;

  // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
  assign shifted = {rem_r, q_r[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, d_r};
  assign ge      = (shifted >= {1'b0, d_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(VALUE_BITS);
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      q_nxt    = {q_r[VALUE_BITS-2:0], ge};
      rem_nxt  = ge ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/core/itrd_store.sv -----
module itrd_store #(
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF,
  parameter int ADDR_W     = $clog2(MAX_DIGITS)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [itrd_pkg::DIGIT_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [itrd_pkg::DIGIT_W-1:0] rd_data
);
  import itrd_pkg::*;

  logic [DIGIT_W-1:0] mem_r [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/integer_to_radix_digits_top.sv -----
// Converts one value into ASCII digits in the configured radix, most significant first.
// Each digit comes from the shared restoring divider, one bit per cycle.
// Emitting goes through a store read (S_READ), then an output hold (S_OUT), for each
// digit; one value is in flight at a time.
// A zero value skips the divider, and output stalls hold the sequencer in S_OUT.
// Reset (synchronous, rst_n low) sets the radix to ten and idles the sequencer.
module integer_to_radix_digits_top #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: value [VALUE_BITS-1:0], zero padding above.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // out_tdata: digit_char [6:0], zero padding [7]. out_tlast: last_digit.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [itrd_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast,
  input  logic                                   cfg_wr_en,
  input  logic [itrd_pkg::RADIX_W-1:0]           cfg_wr_data
);
  import itrd_pkg::*;

  localparam int ADDR_W = $clog2(MAX_DIGITS);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [RADIX_W-1:0]    radix_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]     pos_r, pos_nxt;

  logic                  in_fire;
  logic [VALUE_BITS-1:0] in_value;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_busy;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;

  logic                  st_wr_en;
  logic [ADDR_W-1:0]     st_wr_addr;
  logic [DIGIT_W-1:0]    st_wr_data;
  logic [DIGIT_W-1:0]    st_rd_data;
  logic [CHAR_W-1:0]     out_char;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_value  = in_tdata[VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    div_start    = 1'b0;
    div_dividend = div_quot;
    st_wr_en     = 1'b0;
    st_wr_addr   = cnt_r[ADDR_W-1:0];
    st_wr_data   = div_rem;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_value == '0) begin
            // Zero still yields one digit.
            st_wr_en   = 1'b1;
            st_wr_addr = '0;
            st_wr_data = '0;
            cnt_nxt    = CNT_W'(1);
            pos_nxt    = '0;
            state_nxt  = S_READ;
          end else begin
            div_start    = 1'b1;
            div_dividend = in_value;
            cnt_nxt      = '0;
            state_nxt    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          st_wr_en = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          if ((div_quot == '0) || (cnt_r == CNT_W'(MAX_DIGITS - 1))) begin
            pos_nxt   = cnt_r[ADDR_W-1:0];
            state_nxt = S_READ;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          if (pos_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r - 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
    end
  end

  itrd_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (clamp_radix(radix_r)),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  itrd_store #(
    .MAX_DIGITS(MAX_DIGITS),
    .ADDR_W    (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (pos_r),
    .rd_data (st_rd_data)
  );

  // The store output is registered and stays put while the output waits in S_OUT.
  assign out_char   = digit_to_char(st_rd_data);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {{(OUT_TDATA_W - CHAR_W){1'b0}}, out_char};
  assign out_tlast  = (pos_r == '0);

  a_out_excl_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("result offered while a new transaction is accepted");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider running outside the divide phase");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_char >= CHAR_ZERO) && (out_char <= CHAR_LAST)))
    else $error("digit character out of range");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

endmodule

// ----- dv/integer_to_radix_digits_checker.sv -----
`timescale 1ns / 1ps

module integer_to_radix_digits_checker #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF,
  parameter int IN_W       = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [IN_W-1:0]                  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [itrd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [itrd_pkg::RADIX_W-1:0]     cfg_wr_data,
  output int                               mismatch_count,
  output int                               digits_outstanding
);

  localparam logic [itrd_pkg::CHAR_W-1:0] ASCII_ZERO   = 7'd48;
  localparam logic [itrd_pkg::CHAR_W-1:0] ASCII_LETTER = 7'd55;

  typedef struct packed {
    logic [itrd_pkg::CHAR_W-1:0] digit_char;
    logic                        last_digit;
  } digit_item_t;

  logic [itrd_pkg::RADIX_W-1:0] base_reg;
  digit_item_t                  expected_digits[$];

  // Converts one accepted value and queues its characters, most significant first.
  function automatic void queue_digits(input logic [IN_W-1:0] word,
                                       input logic [itrd_pkg::RADIX_W-1:0] base_cfg);
    longint unsigned n;
    longint unsigned base;
    logic [itrd_pkg::DIGIT_W-1:0] rems [MAX_DIGITS];
    int count;
    digit_item_t item;
    n = longint'(word) & ((64'd1 << VALUE_BITS) - 64'd1);
    if (base_cfg < 6'd2) begin
      base = 2;
    end else if (base_cfg > 6'd36) begin
      base = 36;
    end else begin
      base = base_cfg;
    end
    count = 0;
    if (n == 0) begin
      rems[0] = '0;
      count = 1;
    end else begin
      while (n != 0 && count < MAX_DIGITS) begin
        rems[count] = itrd_pkg::DIGIT_W'(n % base);
        n = n / base;
        count++;
      end
    end
    for (int k = count - 1; k >= 0; k--) begin
      if (rems[k] < 6'd10) begin
        item.digit_char = ASCII_ZERO + {1'b0, rems[k]};
      end else begin
        item.digit_char = ASCII_LETTER + {1'b0, rems[k]};
      end
      item.last_digit = (k == 0);
      expected_digits.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    digit_item_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      base_reg <= itrd_pkg::RADIX_RESET;
      expected_digits.delete();
      digits_outstanding <= 0;
      mismatch_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        base_reg <= cfg_wr_data;
      end
      // Results are retired before the new value is queued; a result can never
      // belong to a value accepted at the same edge.
      if (out_tvalid && out_tready) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected result: digit_char %0d, last_digit %0d",
                 out_tdata[6:0], out_tlast);
          errs++;
        end else begin
          want = expected_digits.pop_front();
          if (out_tdata[6:0] !== want.digit_char) begin
            $error("digit_char mismatch: expected %0d, actual %0d",
                   want.digit_char, out_tdata[6:0]);
            errs++;
          end
          if (out_tlast !== want.last_digit) begin
            $error("last_digit mismatch: expected %0d, actual %0d",
                   want.last_digit, out_tlast);
            errs++;
          end
          if (out_tdata[7] !== 1'b0) begin
            $error("out_tdata padding mismatch: expected 0, actual %0d", out_tdata[7]);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        queue_digits(in_tdata, base_reg);
      end
      mismatch_count <= mismatch_count + errs;
      digits_outstanding <= expected_digits.size();
    end
  end

endmodule

// ----- dv/tb_integer_to_radix_digits_top.sv -----
`timescale 1ns / 1ps

module tb_integer_to_radix_digits_top;

  localparam int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF;
  localparam int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF;
  localparam int IN_W       = ((VALUE_BITS + 7) / 8) * 8;

  logic                             clk;
  logic                             rst_n       = 1'b0;
  logic                             in_tvalid   = 1'b0;
  logic                             in_tready;
  logic [IN_W-1:0]                  in_tdata    = '0;
  logic                             out_tvalid;
  logic                             out_tready  = 1'b0;
  logic [itrd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;
  logic                             cfg_wr_en   = 1'b0;
  logic [itrd_pkg::RADIX_W-1:0]     cfg_wr_data = '0;

  int mismatch_count;
  int digits_outstanding;
  bit steady_in  = 1'b0;
  bit steady_out = 1'b0;
  int ready_hold = 0;

  integer_to_radix_digits_top #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  integer_to_radix_digits_checker #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tlast         (out_tlast),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .mismatch_count    (mismatch_count),
    .digits_outstanding(digits_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("integer_to_radix_digits_top verification failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) begin
      return 0;
    end else if (p < 85) begin
      return $urandom_range(1, 3);
    end else if (p < 97) begin
      return $urandom_range(4, 12);
    end else begin
      return $urandom_range(20, 60);
    end
  endfunction

  always @(posedge clk) begin
    if (steady_out) begin
      out_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
      ready_hold <= pick_gap();
    end
  end

  function automatic logic [IN_W-1:0] pick_value();
    logic [IN_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 40);
      1: v = $urandom >> $urandom_range(1, 31);
      2: v = 32'h7FFF_FFFF - $urandom_range(0, 100);
      3: v = $urandom & 32'h7FFF_FFFF;
      4: v = $urandom & 32'h7FFF_FFFF;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [itrd_pkg::RADIX_W-1:0] pick_radix();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) begin
      return itrd_pkg::RADIX_W'($urandom_range(0, 1));
    end else if (p < 16) begin
      return itrd_pkg::RADIX_W'($urandom_range(37, 63));
    end else if (p < 24) begin
      return 6'd2;
    end else if (p < 32) begin
      return 6'd36;
    end else begin
      return itrd_pkg::RADIX_W'($urandom_range(2, 36));
    end
  endfunction

  task automatic send_value(input logic [IN_W-1:0] v);
    int gap;
    in_tdata  <= v;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = steady_in ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Every value yields digits, so the block is idle once all of them are back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (digits_outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_radix(input logic [itrd_pkg::RADIX_W-1:0] r);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset radix of ten: zero, small values, the full range and the ignored top bit.
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1234567890);

    set_radix(6'd2);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'h7FFF_FFFF);
    send_value(32'h5555_5555);

    set_radix(6'd36);
    send_value(32'd35);
    send_value(32'd36);
    send_value(32'h7FFF_FFFF);
    send_value(32'd1295);

    set_radix(6'd16);
    send_value(32'h12AB_CDEF);

    // Out-of-range radix settings saturate to two or thirty-six.
    set_radix(6'd0);
    send_value(32'd5);
    set_radix(6'd1);
    send_value(32'd6);
    set_radix(6'd37);
    send_value(32'd1295);
    set_radix(6'd63);
    send_value(32'd46655);

    for (int phase = 0; phase < 9; phase++) begin
      set_radix(pick_radix());
      steady_in  = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 30; i++) begin
        send_value(pick_value());
      end
    end
    steady_out = 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && digits_outstanding == 0) begin
      $display("integer_to_radix_digits_top verification clean");
    end else begin
      $display("integer_to_radix_digits_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/itrd_pkg.sv
rtl/core/itrd_div.sv
rtl/core/itrd_store.sv
rtl/core/integer_to_radix_digits_top.sv
dv/integer_to_radix_digits_checker.sv
dv/tb_integer_to_radix_digits_top.sv
